// File: rtl/qau_pkg.sv
`default_nettype none

package qau_pkg;

  localparam int COMP_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int SCALAR_W       = 35;
  localparam int NUM_COMP       = 4;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_NEG   = 3'd2,
    CMD_MUL   = 3'd3,
    CMD_SCALE = 3'd4,
    CMD_CONJ  = 3'd5,
    CMD_DOT   = 3'd6,
    CMD_NORM  = 3'd7
  } cmd_t;

  // Load strobes for the three register stages.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic load_c;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/qau_req_if.sv
`default_nettype none

interface qau_req_if #(
  parameter int W = qau_pkg::COMP_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  qau_pkg::cmd_t       cmd;
  logic signed [W-1:0] q_w;
  logic signed [W-1:0] q_x;
  logic signed [W-1:0] q_y;
  logic signed [W-1:0] q_z;
  logic signed [W-1:0] r_w;
  logic signed [W-1:0] r_x;
  logic signed [W-1:0] r_y;
  logic signed [W-1:0] r_z;
  logic signed [W-1:0] scale;

  modport source (
    output valid, cmd, q_w, q_x, q_y, q_z, r_w, r_x, r_y, r_z, scale,
    input  ready
  );
  modport sink (
    input  valid, cmd, q_w, q_x, q_y, q_z, r_w, r_x, r_y, r_z, scale,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/qau_rsp_if.sv
`default_nettype none

interface qau_rsp_if #(
  parameter int W = qau_pkg::COMP_WIDTH_DEF
);
  logic                               valid;
  logic                               ready;
  logic signed [W-1:0]                res_w;
  logic signed [W-1:0]                res_x;
  logic signed [W-1:0]                res_y;
  logic signed [W-1:0]                res_z;
  logic signed [qau_pkg::SCALAR_W-1:0] res_scalar;
  logic                               saturated;

  modport source (
    output valid, res_w, res_x, res_y, res_z, res_scalar, saturated,
    input  ready
  );
  modport sink (
    input  valid, res_w, res_x, res_y, res_z, res_scalar, saturated,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/quaternion_arith_unit_top.sv
// Channel   Modport  Transfer          Payload
// req       sink     valid && ready    cmd, q_w..q_z, r_w..r_z, scale
// rsp       source   valid && ready    res_w..res_z, res_scalar, saturated
//
// Three register stages: input register, product register, result register.
// rsp valid rises once a req item has passed the input, product and result registers;
// one item can be taken in every cycle while rsp is not stalled.
// The sixteen-multiplier array between the first two stages is the longest path.
// Synchronous reset empties all stages; a stalled rsp holds its stage and
// those behind it fill up before req ready falls.
`default_nettype none

module quaternion_arith_unit_top #(
  parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  qau_req_if.sink   req,
  qau_rsp_if.source rsp
);
  import qau_pkg::*;

  pipe_ctrl_t ctrl;
  logic       valid_a;
  logic       valid_b;
  logic       valid_c;
  logic       en_a;
  logic       en_b;
  logic       en_c;

  cmd_t                         cmd_b;
  logic signed [2*COMP_WIDTH-1:0] prod_b [NUM_COMP][NUM_COMP];
  logic signed [COMP_WIDTH-1:0]   lin_b  [NUM_COMP];
  logic                           lin_sat_b [NUM_COMP];

  // A stage may load when it is empty or its contents move on this cycle.
  assign en_c = !valid_c || rsp.ready;
  assign en_b = !valid_b || en_c;
  assign en_a = !valid_a || en_b;

  assign ctrl.load_a = en_a && req.valid;
  assign ctrl.load_b = en_b && valid_a;
  assign ctrl.load_c = en_c && valid_b;

  assign req.ready = en_a;
  assign rsp.valid = valid_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else begin
      if (en_a) valid_a <= req.valid;
      if (en_b) valid_b <= valid_a;
      if (en_c) valid_c <= valid_b;
    end
  end

  qau_mul #(
    .COMP_WIDTH (COMP_WIDTH)
  ) u_mul (
    .clk       (clk),
    .ctrl      (ctrl),
    .req       (req),
    .cmd_b     (cmd_b),
    .prod_b    (prod_b),
    .lin_b     (lin_b),
    .lin_sat_b (lin_sat_b)
  );

  qau_fin #(
    .COMP_WIDTH (COMP_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_fin (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cmd_b     (cmd_b),
    .prod_b    (prod_b),
    .lin_b     (lin_b),
    .lin_sat_b (lin_sat_b),
    .rsp       (rsp)
  );

`ifndef NO_ASSERTIONS
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !valid_a && !valid_b && !valid_c)
    else $error("pipeline not empty after reset");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    valid_a && valid_b && valid_c && !rsp.ready |-> !req.ready)
    else $error("transfer taken while every stage is held");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    valid_b && !en_c |=> valid_b && valid_c)
    else $error("held product stage lost its item");
`endif

endmodule

`default_nettype wire

// File: rtl/qau_mul.sv
`default_nettype none

module qau_mul #(
  parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire qau_pkg::pipe_ctrl_t        ctrl,
  qau_req_if.sink                         req,
  output qau_pkg::cmd_t                   cmd_b,
  output logic signed [2*COMP_WIDTH-1:0]  prod_b [qau_pkg::NUM_COMP][qau_pkg::NUM_COMP],
  output logic signed [COMP_WIDTH-1:0]    lin_b  [qau_pkg::NUM_COMP],
  output logic                            lin_sat_b [qau_pkg::NUM_COMP]
);
  import qau_pkg::*;

  localparam int W  = COMP_WIDTH;
  localparam int PW = 2 * W;
  localparam int LW = W + 1;
  localparam logic signed [LW-1:0] HI = LW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [LW-1:0] LO = -HI - LW'(1);

  cmd_t                cmd_a;
  logic signed [W-1:0] qa [NUM_COMP];
  logic signed [W-1:0] ra [NUM_COMP];
  logic signed [W-1:0] sa;
  logic signed [W-1:0] bsel [NUM_COMP];
  logic signed [LW-1:0] lin_raw [NUM_COMP];

  // Input register.
  always_ff @(posedge clk) begin
    if (ctrl.load_a) begin
      cmd_a <= req.cmd;
      qa[0] <= req.q_w;
      qa[1] <= req.q_x;
      qa[2] <= req.q_y;
      qa[3] <= req.q_z;
      ra[0] <= req.r_w;
      ra[1] <= req.r_x;
      ra[2] <= req.r_y;
      ra[3] <= req.r_z;
      sa    <= req.scale;
    end
  end

  // The multiplier array is shared: norm squares q, scale puts the factor
  // in every column, and everything else multiplies by r.
  always_comb begin
    for (int j = 0; j < NUM_COMP; j++) begin
      case (cmd_a)
        CMD_NORM:  bsel[j] = qa[j];
        CMD_SCALE: bsel[j] = sa;
        default:   bsel[j] = ra[j];
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      case (cmd_a)
        CMD_ADD:  lin_raw[i] = LW'(qa[i]) + LW'(ra[i]);
        CMD_SUB:  lin_raw[i] = LW'(qa[i]) - LW'(ra[i]);
        CMD_CONJ: lin_raw[i] = (i == 0) ? LW'(qa[i]) : -LW'(qa[i]);
        default:  lin_raw[i] = -LW'(qa[i]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_b) begin
      cmd_b <= cmd_a;
      for (int i = 0; i < NUM_COMP; i++) begin
        for (int j = 0; j < NUM_COMP; j++) begin
          prod_b[i][j] <= PW'(qa[i]) * PW'(bsel[j]);
        end
        if (lin_raw[i] > HI) begin
          lin_b[i]     <= W'(HI);
          lin_sat_b[i] <= 1'b1;
        end else if (lin_raw[i] < LO) begin
          lin_b[i]     <= W'(LO);
          lin_sat_b[i] <= 1'b1;
        end else begin
          lin_b[i]     <= W'(lin_raw[i]);
          lin_sat_b[i] <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/qau_fin.sv
`default_nettype none

module qau_fin #(
  parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire qau_pkg::pipe_ctrl_t             ctrl,
  input  wire qau_pkg::cmd_t                   cmd_b,
  input  wire logic signed [2*COMP_WIDTH-1:0]  prod_b [qau_pkg::NUM_COMP][qau_pkg::NUM_COMP],
  input  wire logic signed [COMP_WIDTH-1:0]    lin_b  [qau_pkg::NUM_COMP],
  input  wire logic                            lin_sat_b [qau_pkg::NUM_COMP],
  qau_rsp_if.source                            rsp
);
  import qau_pkg::*;

  localparam int W  = COMP_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int SW = 2 * W + 2;
  localparam int EW = (SW > F + 1) ? SW : F + 2;
  localparam int XW = (SW > SCALAR_W) ? SW : SCALAR_W;
  localparam logic signed [EW-1:0] HALF = EW'(64'sd1 <<< (F - 1));
  localparam logic signed [EW-1:0] HI   = EW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] LO   = -HI - EW'(1);

  logic signed [SW-1:0] ext [NUM_COMP][NUM_COMP];
  logic signed [SW-1:0] qsum [NUM_COMP];
  logic signed [SW-1:0] dsum;
  logic signed [XW-1:0] dsum_x;
  logic signed [EW-1:0] rnd [NUM_COMP];
  logic signed [W-1:0]  res [NUM_COMP];
  logic                 sat [NUM_COMP];
  logic signed [W-1:0]  res_next [NUM_COMP];
  logic                 sat_next;
  logic signed [SCALAR_W-1:0] scalar_next;

  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        ext[i][j] = SW'(prod_b[i][j]);
      end
    end
  end

  // Hamilton product terms and the dot sum; scale takes column zero alone.
  always_comb begin
    if (cmd_b == CMD_SCALE) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        qsum[i] = ext[i][0];
      end
    end else begin
      qsum[0] = ext[0][0] - ext[1][1] - ext[2][2] - ext[3][3];
      qsum[1] = ext[0][1] + ext[1][0] + ext[2][3] - ext[3][2];
      qsum[2] = ext[0][2] - ext[1][3] + ext[2][0] + ext[3][1];
      qsum[3] = ext[0][3] + ext[1][2] - ext[2][1] + ext[3][0];
    end
    dsum   = ext[0][0] + ext[1][1] + ext[2][2] + ext[3][3];
    dsum_x = XW'(dsum);
  end

  // Round half up, then clip to the component range.
  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      rnd[i] = (EW'(qsum[i]) + HALF) >>> F;
      if (rnd[i] > HI) begin
        res[i] = W'(HI);
        sat[i] = 1'b1;
      end else if (rnd[i] < LO) begin
        res[i] = W'(LO);
        sat[i] = 1'b1;
      end else begin
        res[i] = W'(rnd[i]);
        sat[i] = 1'b0;
      end
    end
  end

  always_comb begin
    scalar_next = '0;
    sat_next    = 1'b0;
    for (int i = 0; i < NUM_COMP; i++) begin
      res_next[i] = '0;
    end
    case (cmd_b)
      CMD_MUL, CMD_SCALE: begin
        for (int i = 0; i < NUM_COMP; i++) begin
          res_next[i] = res[i];
        end
        sat_next = sat[0] | sat[1] | sat[2] | sat[3];
      end
      CMD_DOT, CMD_NORM: begin
        scalar_next = dsum_x[SCALAR_W-1:0];
      end
      default: begin
        for (int i = 0; i < NUM_COMP; i++) begin
          res_next[i] = lin_b[i];
        end
        sat_next = lin_sat_b[0] | lin_sat_b[1] | lin_sat_b[2] | lin_sat_b[3];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_c) begin
      rsp.res_w      <= res_next[0];
      rsp.res_x      <= res_next[1];
      rsp.res_y      <= res_next[2];
      rsp.res_z      <= res_next[3];
      rsp.res_scalar <= scalar_next;
      rsp.saturated  <= sat_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_scalar_quat_zero: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_c && (cmd_b == CMD_DOT || cmd_b == CMD_NORM) |=>
      rsp.res_w == '0 && rsp.res_x == '0 && rsp.res_y == '0 && rsp.res_z == '0
      && !rsp.saturated)
    else $error("dot or norm result carries a quaternion part or a flag");

  a_quat_scalar_zero: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_c && cmd_b != CMD_DOT && cmd_b != CMD_NORM |=> rsp.res_scalar == '0)
    else $error("quaternion result carries a scalar part");

  a_conj_keeps_w: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_c && cmd_b == CMD_CONJ |-> !lin_sat_b[0])
    else $error("conjugate flagged a clip on the scalar part");
`endif

endmodule

`default_nettype wire

// File: dv/quaternion_arith_unit_top_test.sv
`timescale 1ns / 100ps

module quaternion_arith_unit_top_test;
  import qau_pkg::*;

  localparam int COMP_W = COMP_WIDTH_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint CMAX = (longint'(1) << (COMP_W - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam longint ONE = longint'(1) << FRAC;
  localparam int N_RANDOM = 1850;
  localparam int MAX_WAIT = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [NUM_COMP-1:0][COMP_W-1:0] quat_t;  // index 0 is w, then x, y, z

  typedef struct packed {
    cmd_t              cmd;
    quat_t             q;
    quat_t             r;
    logic [COMP_W-1:0] scale;
  } quat_op_t;

  typedef struct packed {
    quat_t                      comp;
    logic signed [SCALAR_W-1:0] scalar;
    logic                       sat;
  } quat_res_t;

  typedef struct {
    quat_op_t  op;
    bit        typed;
    quat_res_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  qau_req_if req ();
  qau_rsp_if rsp ();

  quaternion_arith_unit_top dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  quat_res_t pending_res [$];
  int        err_cnt = 0;
  int        idle_cnt = 0;
  string     comp_name [NUM_COMP] = '{"w", "x", "y", "z"};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic quat_res_t quat_result(quat_op_t op);
    longint a [NUM_COMP];
    longint b [NUM_COMP];
    longint v [NUM_COMP];
    longint s;
    longint acc;
    quat_res_t res;
    res = '0;
    acc = 0;
    s = longint'($signed(op.scale));
    for (int i = 0; i < NUM_COMP; i++) begin
      a[i] = longint'($signed(op.q[i]));
      b[i] = longint'($signed(op.r[i]));
      v[i] = 0;
    end
    case (op.cmd)
      CMD_ADD: for (int i = 0; i < NUM_COMP; i++) v[i] = a[i] + b[i];
      CMD_SUB: for (int i = 0; i < NUM_COMP; i++) v[i] = a[i] - b[i];
      CMD_NEG: for (int i = 0; i < NUM_COMP; i++) v[i] = -a[i];
      CMD_CONJ: begin
        v[0] = a[0];
        for (int i = 1; i < NUM_COMP; i++) v[i] = -a[i];
      end
      CMD_MUL: begin
        v[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
        v[1] = a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2];
        v[2] = a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1];
        v[3] = a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0];
        for (int i = 0; i < NUM_COMP; i++) v[i] = (v[i] + (ONE >>> 1)) >>> FRAC;
      end
      CMD_SCALE: begin
        for (int i = 0; i < NUM_COMP; i++) v[i] = (s * a[i] + (ONE >>> 1)) >>> FRAC;
      end
      CMD_DOT: for (int i = 0; i < NUM_COMP; i++) acc += a[i] * b[i];
      default: for (int i = 0; i < NUM_COMP; i++) acc += a[i] * a[i];
    endcase
    if (op.cmd == CMD_DOT || op.cmd == CMD_NORM) begin
      res.scalar = SCALAR_W'(acc);
    end else begin
      for (int i = 0; i < NUM_COMP; i++) begin
        if (v[i] > CMAX) begin
          v[i] = CMAX;
          res.sat = 1'b1;
        end else if (v[i] < CMIN) begin
          v[i] = CMIN;
          res.sat = 1'b1;
        end
        res.comp[i] = COMP_W'(v[i]);
      end
    end
    return res;
  endfunction

  function automatic quat_op_t op_of(cmd_t cmd, longint qw, qx, qy, qz, rw, rx, ry, rz, s);
    quat_op_t op;
    op.cmd = cmd;
    op.q = {COMP_W'(qz), COMP_W'(qy), COMP_W'(qx), COMP_W'(qw)};
    op.r = {COMP_W'(rz), COMP_W'(ry), COMP_W'(rx), COMP_W'(rw)};
    op.scale = COMP_W'(s);
    return op;
  endfunction

  function automatic quat_res_t res_of(longint w, x, y, z, sc, bit sat);
    quat_res_t res;
    res.comp = {COMP_W'(z), COMP_W'(y), COMP_W'(x), COMP_W'(w)};
    res.scalar = SCALAR_W'(sc);
    res.sat = sat;
    return res;
  endfunction

  // Extremes, zero, unit and small values turn up often, the rest is uniform.
  function automatic logic [COMP_W-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return COMP_W'(CMIN);
      1: return COMP_W'(CMAX);
      2: return '0;
      3: return COMP_W'(ONE);
      4: return COMP_W'(-ONE);
      5: return COMP_W'($urandom_range(0, 16) - 8);
      default: return COMP_W'($urandom);
    endcase
  endfunction

  task automatic send_op(quat_op_t op, bit typed, quat_res_t want, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= op.cmd;
    req.q_w <= op.q[0];
    req.q_x <= op.q[1];
    req.q_y <= op.q[2];
    req.q_z <= op.q[3];
    req.r_w <= op.r[0];
    req.r_x <= op.r[1];
    req.r_y <= op.r[2];
    req.r_z <= op.r[3];
    req.scale <= op.scale;
    do @(posedge clk); while (req.ready !== 1'b1);
    pending_res.push_back(typed ? want : quat_result(op));
  endtask

  task automatic check_result(quat_res_t got);
    quat_res_t want;
    if (pending_res.size() == 0) begin
      $display("%0t: result with no operation pending: w=%0d x=%0d y=%0d z=%0d scalar=%0d",
               $time, $signed(got.comp[0]), $signed(got.comp[1]), $signed(got.comp[2]),
               $signed(got.comp[3]), got.scalar);
      err_cnt++;
    end else begin
      want = pending_res.pop_front();
      for (int i = 0; i < NUM_COMP; i++) begin
        if (got.comp[i] !== want.comp[i]) begin
          $display("%0t: res_%s expected %0d, got %0d", $time, comp_name[i],
                   $signed(want.comp[i]), $signed(got.comp[i]));
          err_cnt++;
        end
      end
      if (got.scalar !== want.scalar) begin
        $display("%0t: res_scalar expected %0d, got %0d", $time, want.scalar, got.scalar);
        err_cnt++;
      end
      if (got.sat !== want.sat) begin
        $display("%0t: saturated expected %0b, got %0b", $time, want.sat, got.sat);
        err_cnt++;
      end
    end
  endtask

  initial begin : stimulus
    dir_row_t dir_tab [$];
    quat_op_t op;
    bit       tx_burst;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.cmd <= CMD_ADD;
    req.q_w <= '0;
    req.q_x <= '0;
    req.q_y <= '0;
    req.q_z <= '0;
    req.r_w <= '0;
    req.r_x <= '0;
    req.r_y <= '0;
    req.r_z <= '0;
    req.scale <= '0;

    // Rows with an obvious answer carry it; the others go through the predictor.
    dir_tab.push_back(dir_row_t'{op_of(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                 res_of(0, 0, 0, 0, 0, 1'b0)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_ADD, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                                       CMAX, 0), 1'b1, res_of(CMAX, CMAX, CMAX, CMAX, 0, 1'b1)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_ADD, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                                       CMIN, CMAX), 1'b1, res_of(CMIN, CMIN, CMIN, CMIN, 0, 1'b1)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_ADD, CMAX, CMIN, 1, -1, CMIN, CMAX, -1, 1, 0), 1'b1,
                                 res_of(-1, -1, 0, 0, 0, 1'b0)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_SUB, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                                       CMIN, 0), 1'b1, res_of(CMAX, CMAX, CMAX, CMAX, 0, 1'b1)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_SUB, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                                       CMAX, 0), 1'b1, res_of(CMIN, CMIN, CMIN, CMIN, 0, 1'b1)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_NEG, CMIN, CMIN, CMIN, CMIN, CMAX, 0, 0, 0, 0),
                                 1'b1, res_of(CMAX, CMAX, CMAX, CMAX, 0, 1'b1)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_NEG, CMAX, 0, 1, -1, CMIN, 0, 0, 0, CMIN), 1'b1,
                                 res_of(-CMAX, 0, -1, 1, 0, 1'b0)});
    // i * j = k and j * i = -k pin down the signs of the cross terms.
    dir_tab.push_back(dir_row_t'{op_of(CMD_MUL, 0, ONE, 0, 0, 0, 0, ONE, 0, 0), 1'b1,
                                 res_of(0, 0, 0, ONE, 0, 1'b0)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_MUL, 0, 0, ONE, 0, 0, ONE, 0, 0, 0), 1'b1,
                                 res_of(0, 0, 0, -ONE, 0, 1'b0)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_MUL, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                                       CMIN, 0), 1'b0, '0});
    dir_tab.push_back(dir_row_t'{op_of(CMD_MUL, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                                       CMIN, 0), 1'b0, '0});
    dir_tab.push_back(dir_row_t'{op_of(CMD_MUL, 1, 1, 1, -1, 8192, 8192, 8192, 8192, 0),
                                 1'b0, '0});
    dir_tab.push_back(dir_row_t'{op_of(CMD_MUL, ONE, 1234, -5678, 91, -300, 7000, 25, -16000,
                                       0), 1'b0, '0});
    dir_tab.push_back(dir_row_t'{op_of(CMD_SCALE, CMIN, CMAX, 1, -1, 0, 0, 0, 0, CMIN), 1'b0,
                                 '0});
    dir_tab.push_back(dir_row_t'{op_of(CMD_SCALE, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                                       CMIN, 0), 1'b1, res_of(0, 0, 0, 0, 0, 1'b0)});
    // Halfway cases round upwards, towards plus infinity.
    dir_tab.push_back(dir_row_t'{op_of(CMD_SCALE, 1, -1, 3, -3, 0, 0, 0, 0, 8192), 1'b0, '0});
    dir_tab.push_back(dir_row_t'{op_of(CMD_CONJ, CMIN, CMIN, CMIN, CMIN, 0, 0, 0, 0, 0), 1'b1,
                                 res_of(CMIN, CMAX, CMAX, CMAX, 0, 1'b1)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_CONJ, 100, -200, 300, 0, CMAX, CMAX, CMAX, CMAX,
                                       CMAX), 1'b1, res_of(100, 200, -300, 0, 0, 1'b0)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_DOT, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                                       CMIN, 0), 1'b1, res_of(0, 0, 0, 0, 64'sd4294967296, 1'b0)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_DOT, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                                       CMIN, CMAX), 1'b0, '0});
    dir_tab.push_back(dir_row_t'{op_of(CMD_NORM, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                                       CMAX, 0), 1'b1, res_of(0, 0, 0, 0, 64'sd4294967296, 1'b0)});
    dir_tab.push_back(dir_row_t'{op_of(CMD_NORM, 0, 0, 0, 0, CMIN, CMIN, CMIN, CMIN, CMIN),
                                 1'b1, res_of(0, 0, 0, 0, 0, 1'b0)});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_op(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want, 1'b0);

    tx_burst = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 128 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      op.cmd = cmd_t'($urandom_range(0, 7));
      for (int k = 0; k < NUM_COMP; k++) begin
        op.q[k] = rand_comp();
        op.r[k] = rand_comp();
      end
      op.scale = rand_comp();
      send_op(op, 1'b0, '0, tx_burst);
    end
    req.valid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : result_side
    quat_res_t got;
    int        stall;
    int        n_res;
    bit        rx_burst;
    n_res = 0;
    rx_burst = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (n_res % 100 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      got.comp = {rsp.res_z, rsp.res_y, rsp.res_x, rsp.res_w};
      got.scalar = rsp.res_scalar;
      got.sat = rsp.saturated;
      check_result(got);
      n_res++;
    end
  end

  // A transfer on either channel counts as progress.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
